// File: rtl/vpd_pkg.sv
// Package with shared types and helpers for the vertex position dedup core.
package vpd_pkg;

  // One stored position: three float bit patterns.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vpd_pos_t;

  // Search request traveling down the chain of cells.
  typedef struct packed {
    logic     active;
    logic     found;
    logic [15:0] hit_index;
    vpd_pos_t pos;
  } vpd_probe_t;

  // Float equality on bit patterns: NaN never matches, +0 equals -0.
  function automatic logic comp_equal(input logic [31:0] a, input logic [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    ma = a[30:0];
    mb = b[30:0];
    if ((ma > 31'h7F800000) || (mb > 31'h7F800000)) begin
      return 1'b0;
    end
    if ((ma == 31'd0) && (mb == 31'd0)) begin
      return 1'b1;
    end
    return a == b;
  endfunction

  function automatic logic pos_equal(input vpd_pos_t a, input vpd_pos_t b);
    return comp_equal(a.x, b.x) && comp_equal(a.y, b.y) && comp_equal(a.z, b.z);
  endfunction

endpackage

// File: rtl/vertex_position_dedup_core.sv
// Top level of the vertex position dedup core: control and the chain of cells.
// A request is taken when start is high and busy is low. It then walks the
// chain of TABLE_DEPTH cells, one cell per cycle, and the result appears on
// done for one cycle, registered after the last cell of the chain; busy
// stays high until done has been shown, so no new vertex is taken while
// one is still in flight.
// The receiver cannot stall: results must be taken in the cycle shown.
module vertex_position_dedup_core
  import vpd_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic        start_of_mesh,
  output logic        done,
  output logic [7:0]  unique_index,
  output logic        is_new,
  output logic        overflow,
  output logic [8:0]  unique_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  vpd_probe_t            chain [TABLE_DEPTH+1];
  logic [CNT_W-1:0]      stored_count;
  logic [CNT_W-1:0]      count_next;
  logic                  clear_tbl;
  logic                  finish;
  logic                  full;

  assign finish = chain[TABLE_DEPTH].active;
  assign full   = (stored_count == CNT_W'(TABLE_DEPTH));

  // Injection into the head of the chain.
  always_comb begin
    chain[0].active    = start && !busy;
    chain[0].found     = 1'b0;
    chain[0].hit_index = 16'd0;
    chain[0].pos       = '{x: pos_x, y: pos_y, z: pos_z};
  end

  assign clear_tbl = start && !busy && start_of_mesh;

  // The row of cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic st;
    assign st = finish && !chain[TABLE_DEPTH].found && !full &&
                (stored_count[IDX_W-1:0] == IDX_W'(g));
    vpd_cell #(.IDX_W(IDX_W)) u_cell (
      .clk(clk), .rst(rst), .cell_index(IDX_W'(g)), .clear(clear_tbl),
      .store(st), .store_pos(chain[TABLE_DEPTH].pos),
      .probe_in(chain[g]), .probe_out(chain[g+1])
    );
  end

  // Count of stored entries.
  always_comb begin
    count_next = clear_tbl ? '0 : stored_count;
    if (finish && !chain[TABLE_DEPTH].found && !full) begin
      count_next = stored_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      busy         <= 1'b0;
      done         <= 1'b0;
    end else begin
      stored_count <= count_next;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      done <= finish;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (finish) begin
      unique_count <= 9'(count_next);
      if (chain[TABLE_DEPTH].found) begin
        unique_index <= chain[TABLE_DEPTH].hit_index[7:0];
        is_new       <= 1'b0;
        overflow     <= 1'b0;
      end else if (!full) begin
        unique_index <= 8'(stored_count);
        is_new       <= 1'b1;
        overflow     <= 1'b0;
      end else begin
        unique_index <= 8'd0;
        is_new       <= 1'b0;
        overflow     <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/vpd_cell.sv
// One table cell: holds an entry and compares the passing request against it.
module vpd_cell
  import vpd_pkg::*;
#(
  parameter int IDX_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              clear,
  input  logic              store,
  input  vpd_pos_t          store_pos,
  input  vpd_probe_t        probe_in,
  output vpd_probe_t        probe_out
);

  logic     valid;
  vpd_pos_t entry;

  // Entry storage; valid is cleared on reset and at the start of a mesh.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (store) begin
      valid <= 1'b1;
    end
    if (store) begin
      entry <= store_pos;
    end
  end

  // Hand the request to the next cell, marking the first match.
  // A clear in this cycle empties the table, so the old entry must not match.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    probe_out.pos <= probe_in.pos;
    if (probe_in.active && !probe_in.found && valid && !clear &&
        pos_equal(entry, probe_in.pos)) begin
      probe_out.found     <= 1'b1;
      probe_out.hit_index <= 16'(cell_index);
    end else begin
      probe_out.found     <= probe_in.found;
      probe_out.hit_index <= probe_in.hit_index;
    end
  end

endmodule

// File: rtl/vpd_checker.sv
// Port-level checker for the vertex position dedup core, bound to the top level.
module vpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       is_new,
  input logic       overflow,
  input logic [8:0] unique_count
);

  // A result is only shown while a request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // A new entry and an overflow never come together.
  a_excl: assert property (@(posedge clk) disable iff (rst) done |-> !(is_new && overflow))
    else $error("is_new with overflow");

  // Busy drops right after a result.
  a_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after done");

  // An accepted request raises busy.
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised");

  // A new entry means the count is nonzero.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && is_new) |-> (unique_count != 9'd0))
    else $error("new entry with zero count");

endmodule

bind vertex_position_dedup_core vpd_checker u_vpd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .is_new(is_new), .overflow(overflow), .unique_count(unique_count)
);
